/* sv/pdaf_pkg.sv */
// pdaf_pkg: widths, register indexes and sequencer states of the ppg derivative artifact filter
// used by the channel interfaces, the divider and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package pdaf_pkg;

	// sample and fixed point format
	localparam int SAMPLE_BITS = 18;
	localparam int FRAC_BITS   = 16;
	localparam int AVG_BITS    = 24;
	localparam int COUNT_BITS  = 32;

	// derivative quotient: sample difference shifted up by the fraction bits
	localparam int QUOT_BITS = SAMPLE_BITS + FRAC_BITS;
	localparam int EXT_BITS  = QUOT_BITS + AVG_BITS;
	localparam logic [AVG_BITS-1:0] AVG_MAX = {AVG_BITS{1'b1}};

	// configuration register widths
	localparam int MIN_NORM_BITS = 24;
	localparam int FACTOR_BITS   = 8;
	localparam int ALPHA_FRAC    = 16;
	localparam int ALPHA_BITS    = ALPHA_FRAC + 1;
	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1) << ALPHA_FRAC;

	// shared multiplier: average or derivative times factor or weight
	localparam int MUL_A_BITS = AVG_BITS;
	localparam int MUL_B_BITS = ALPHA_BITS;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int SUM_BITS   = PROD_BITS + 1;
	localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (ALPHA_FRAC - 1);

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MIN_NORM     = 2'd0,
		REG_DERIV_FACTOR = 2'd1,
		REG_EMA_ALPHA    = 2'd2
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_THR,
		ST_CMP,
		ST_EMA1,
		ST_EMA2,
		ST_EMA3,
		ST_OUT
	} seq_state_t;

endpackage : pdaf_pkg

`default_nettype wire

/* sv/pdaf_if.sv */
// pdaf_if: valid/ready channel interfaces for sample pairs, results and register writes
// depends on pdaf_pkg for the payload widths
`timescale 1ns / 1ps
`default_nettype none

interface pdaf_in_if;
	import pdaf_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] ir_sample;
	logic [SAMPLE_BITS-1:0] red_sample;

	modport source (output valid, output ir_sample, output red_sample, input ready);
	modport sink   (input valid, input ir_sample, input red_sample, output ready);
endinterface : pdaf_in_if

interface pdaf_out_if;
	import pdaf_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] ir_clean;
	logic [SAMPLE_BITS-1:0] red_clean;
	logic                   is_artifact;
	logic [COUNT_BITS-1:0]  artifact_total;

	modport source (output valid, output ir_clean, output red_clean, output is_artifact,
		output artifact_total, input ready);
	modport sink   (input valid, input ir_clean, input red_clean, input is_artifact,
		input artifact_total, output ready);
endinterface : pdaf_out_if

interface pdaf_cfg_if;
	import pdaf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface : pdaf_cfg_if

`default_nettype wire

/* sv/pdaf_div.sv */
// pdaf_div: restoring divider, one quotient bit per cycle
// depends on pdaf_pkg for the numerator and denominator widths
`timescale 1ns / 1ps
`default_nettype none

module pdaf_div (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire [pdaf_pkg::QUOT_BITS-1:0]   numer,
	input  wire [pdaf_pkg::SAMPLE_BITS-1:0] denom,
	output logic                            done,
	output logic [pdaf_pkg::QUOT_BITS-1:0]  quot
);
	import pdaf_pkg::*;

	localparam int CNT_BITS = $clog2(QUOT_BITS);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUOT_BITS - 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [QUOT_BITS-1:0]   work_q;
	logic [SAMPLE_BITS:0]   rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [SAMPLE_BITS:0]   rem_sh;
	logic [SAMPLE_BITS:0]   rem_sub;
	logic                   fits;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh  = {rem_q[SAMPLE_BITS-1:0], work_q[QUOT_BITS-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= numer;
			den_q  <= denom;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[QUOT_BITS-2:0], fits};
			rem_q  <= fits ? rem_sub : rem_sh;
		end
	end

	assign done = done_q;
	assign quot = work_q;

endmodule : pdaf_div

`default_nettype wire

/* sv/ppg_derivative_artifact_filter_unit.sv */
// ppg_derivative_artifact_filter_unit: top level of the optical sample artifact filter
// depends on pdaf_pkg, pdaf_if and pdaf_div
//
// Usage
//   samples : infrared/red pair in, valid/ready; a transfer is taken only when the
//             sequencer is idle
//   results : one result per sample pair: the pair passed on (or the held pair when
//             the sample is rejected), the artifact flag and the running artifact total
//   cfg     : register writes (0 min_norm, 1 deriv_factor, 2 ema_alpha), always ready;
//             other indexes are dropped; write only while no sample is in flight
// Timing
//   the first pair after reset goes straight to the output state; every later pair
//   runs through the bit-serial divider and then the shared multiplier for the threshold
//   and, for a clean sample only, the average update (DIV, THR, CMP, EMA1-EMA3, OUT);
//   the sequencer is back in idle to take the next pair in the same cycle that the result
//   appears; when results are not stalled, the divider sets the rate
// Reset and stalls
//   reset clears the held pair, the running average, the artifact counter and the
//   registers to their defaults; a stalled result sits in the output register and the
//   sequencer waits with the next result until it has gone
`timescale 1ns / 1ps
`default_nettype none

module ppg_derivative_artifact_filter_unit (
	input  wire        clk,
	input  wire        arst_n,
	pdaf_in_if.sink    samples,
	pdaf_out_if.source results,
	pdaf_cfg_if.sink   cfg
);
	import pdaf_pkg::*;

	// configuration registers
	logic [MIN_NORM_BITS-1:0] min_norm_q;
	logic [FACTOR_BITS-1:0]   factor_q;
	logic [ALPHA_BITS-1:0]    alpha_q;

	// filter state
	seq_state_t             state_q, state_d;
	logic                   have_prev_q;
	logic [SAMPLE_BITS-1:0] held_ir_q;
	logic [SAMPLE_BITS-1:0] held_red_q;
	logic [AVG_BITS-1:0]    avg_q;
	logic [COUNT_BITS-1:0]  cnt_q;

	// working registers
	logic [SAMPLE_BITS-1:0] ir_q;
	logic [SAMPLE_BITS-1:0] red_q;
	logic [AVG_BITS-1:0]    x_q;
	logic [PROD_BITS-1:0]   prod_q;
	logic [PROD_BITS-1:0]   acc_q;
	logic                   flag_q;

	// output register
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_ir_q;
	logic [SAMPLE_BITS-1:0] out_red_q;
	logic                   out_flag_q;
	logic [COUNT_BITS-1:0]  out_cnt_q;

	// control
	logic                   in_xfer;
	logic                   out_xfer;
	logic                   out_load;
	logic                   div_start;
	logic                   div_done;
	logic [QUOT_BITS-1:0]   div_quot;
	logic [SAMPLE_BITS-1:0] diff;
	logic [SAMPLE_BITS-1:0] denom;
	logic [EXT_BITS-1:0]    quot_ext;
	logic [AVG_BITS-1:0]    x_sat;
	logic [ALPHA_BITS-1:0]  alpha_eff;
	logic [MUL_A_BITS-1:0]  mul_a;
	logic [MUL_B_BITS-1:0]  mul_b;
	logic [PROD_BITS-1:0]   thr;
	logic                   artifact;
	logic [SUM_BITS-1:0]    ema_sum;

	assign in_xfer  = samples.valid && samples.ready;
	assign out_xfer = results.valid && results.ready;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_norm_q <= MIN_NORM_BITS'(5243);
			factor_q   <= FACTOR_BITS'(10);
			alpha_q    <= ALPHA_BITS'(3277);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MIN_NORM:     min_norm_q <= cfg.data[MIN_NORM_BITS-1:0];
				REG_DERIV_FACTOR: factor_q   <= cfg.data[FACTOR_BITS-1:0];
				REG_EMA_ALPHA:    alpha_q    <= cfg.data[ALPHA_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// divider operands straight from the incoming pair
	always_comb begin
		diff  = (samples.ir_sample >= held_ir_q) ? samples.ir_sample - held_ir_q
			: held_ir_q - samples.ir_sample;
		denom = (held_ir_q == '0) ? SAMPLE_BITS'(1) : held_ir_q;
	end

	assign div_start = in_xfer && have_prev_q;

	pdaf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  ({diff, {FRAC_BITS{1'b0}}}),
		.denom  (denom),
		.done   (div_done),
		.quot   (div_quot)
	);

	// saturate the quotient to the average width
	always_comb begin
		quot_ext = EXT_BITS'(div_quot);
		x_sat    = (quot_ext > EXT_BITS'(AVG_MAX)) ? AVG_MAX : quot_ext[AVG_BITS-1:0];
	end

	// shared multiplier operand selection
	always_comb begin
		alpha_eff = alpha_q[ALPHA_FRAC] ? ALPHA_ONE : alpha_q;
		mul_a     = avg_q;
		mul_b     = MUL_B_BITS'(factor_q);
		case (state_q)
			ST_EMA1: begin
				mul_b = ALPHA_ONE - alpha_eff;
			end
			ST_EMA2: begin
				mul_a = x_q;
				mul_b = alpha_eff;
			end
			default: ;
		endcase
	end

	// threshold compare and rounded average
	always_comb begin
		thr      = (prod_q < PROD_BITS'(min_norm_q)) ? PROD_BITS'(min_norm_q) : prod_q;
		artifact = PROD_BITS'(x_q) > thr;
		ema_sum  = SUM_BITS'(acc_q) + SUM_BITS'(prod_q) + ROUND_HALF;
	end

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = have_prev_q ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_THR;
			end
			ST_THR:  state_d = ST_CMP;
			ST_CMP:  state_d = artifact ? ST_OUT : ST_EMA1;
			ST_EMA1: state_d = ST_EMA2;
			ST_EMA2: state_d = ST_EMA3;
			ST_EMA3: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign samples.ready = (state_q == ST_IDLE);

	// filter state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			held_ir_q   <= '0;
			held_red_q  <= '0;
			avg_q       <= '0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					flag_q <= 1'b0;
					if (in_xfer && !have_prev_q) begin
						have_prev_q <= 1'b1;
						held_ir_q   <= samples.ir_sample;
						held_red_q  <= samples.red_sample;
					end
				end
				ST_DIV: begin
					// seed an empty average with the first derivative
					if (div_done && avg_q == '0) avg_q <= x_sat;
				end
				ST_CMP: begin
					if (artifact) begin
						flag_q <= 1'b1;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				ST_EMA3: begin
					avg_q      <= ema_sum[ALPHA_FRAC +: AVG_BITS];
					held_ir_q  <= ir_q;
					held_red_q <= red_q;
				end
				default: ;
			endcase
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ir_q  <= samples.ir_sample;
			red_q <= samples.red_sample;
		end
		if (div_done) x_q <= x_sat;
		if (state_q == ST_THR || state_q == ST_EMA1 || state_q == ST_EMA2) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_EMA2) acc_q <= prod_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ir_q   <= held_ir_q;
			out_red_q  <= held_red_q;
			out_flag_q <= flag_q;
			out_cnt_q  <= cnt_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.ir_clean       = out_ir_q;
	assign results.red_clean      = out_red_q;
	assign results.is_artifact    = out_flag_q;
	assign results.artifact_total = out_cnt_q;

	// divider only completes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider completed outside the divide state");

	// the counter moves only on a rejected sample
	a_cnt_only_on_artifact: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_CMP && artifact) |=> $stable(cnt_q))
		else $error("artifact counter changed without an artifact");

	// the average moves only when seeded or updated
	a_avg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV && state_q != ST_EMA3) |=> $stable(avg_q))
		else $error("running average changed outside seed or update");

	// a result is never overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready && state_q == ST_OUT) |=> state_q == ST_OUT)
		else $error("result register reloaded while stalled");

endmodule : ppg_derivative_artifact_filter_unit

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: self-checking bench for ppg_derivative_artifact_filter_unit
// drives sample pairs and register writes through pdaf_if channels and checks every result
// against a predictor of the derivative threshold filter or a typed expectation; depends on pdaf_pkg and pdaf_if
`timescale 1ns / 1ps

module testbench;
	import pdaf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_PAIRS = 350;
	localparam int PHASE_COUNT = 4;
	localparam int END_SETTLE  = 60;
	localparam int SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	// one result transfer as the block should present it
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] ir;
		logic [SAMPLE_BITS-1:0] red;
		logic                   is_artifact;
		logic [COUNT_BITS-1:0]  total;
	} clean_pair_t;

	// directed script row: a register write or a sample pair, optionally with a typed result
	typedef struct packed {
		bit                        is_write;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
		logic [SAMPLE_BITS-1:0]    ir;
		logic [SAMPLE_BITS-1:0]    red;
		bit                        typed;
		clean_pair_t               want;
	} script_step_t;

	logic clk = 1'b0;
	logic arst_n;

	pdaf_in_if  pair_in ();
	pdaf_out_if pair_out ();
	pdaf_cfg_if reg_wr ();

	ppg_derivative_artifact_filter_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (pair_in),
		.results (pair_out),
		.cfg     (reg_wr)
	);

	// predictor copy of the filter state and registers
	bit                      pair_held;
	bit [SAMPLE_BITS-1:0]    held_ir;
	bit [SAMPLE_BITS-1:0]    held_red;
	bit [AVG_BITS-1:0]       deriv_avg;
	bit [COUNT_BITS-1:0]     artifact_count;
	bit [MIN_NORM_BITS-1:0]  min_norm_reg;
	bit [FACTOR_BITS-1:0]    factor_reg;
	bit [ALPHA_BITS-1:0]     alpha_reg;

	clean_pair_t clean_due[$];
	script_step_t script[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;
	int pairs_sent = 0;
	int results_seen = 0;
	int artifacts_seen = 0;
	int reg_writes = 0;

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// next filter output for one accepted pair, advancing the predictor state
	function automatic clean_pair_t filter_pair(logic [SAMPLE_BITS-1:0] ir,
			logic [SAMPLE_BITS-1:0] red);
		clean_pair_t res;
		bit [63:0] diff;
		bit [63:0] denom;
		bit [63:0] slope;
		bit [63:0] limit;
		bit [63:0] weight;
		bit [63:0] acc;
		res.is_artifact = 1'b0;
		if (!pair_held) begin
			// first pair after reset passes straight through
			pair_held = 1'b1;
			held_ir = ir;
			held_red = red;
		end else begin
			// relative derivative in Q.16, saturated to the average width
			diff = (ir >= held_ir) ? 64'(ir) - 64'(held_ir) : 64'(held_ir) - 64'(ir);
			denom = (held_ir != '0) ? 64'(held_ir) : 64'd1;
			slope = (diff << FRAC_BITS) / denom;
			if (slope > 64'(AVG_MAX))
				slope = 64'(AVG_MAX);
			if (deriv_avg == '0)
				deriv_avg = slope[AVG_BITS-1:0];
			limit = 64'(factor_reg) * 64'(deriv_avg);
			if (limit < 64'(min_norm_reg))
				limit = 64'(min_norm_reg);
			if (slope > limit) begin
				res.is_artifact = 1'b1;
				artifact_count = artifact_count + 1'b1;
			end else begin
				// weighted average, rounded half up; weights above one act as one
				weight = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
				acc = (64'(ALPHA_ONE) - weight) * 64'(deriv_avg) + weight * slope
					+ (64'd1 << (ALPHA_FRAC - 1));
				deriv_avg = acc[ALPHA_FRAC +: AVG_BITS];
				held_ir = ir;
				held_red = red;
			end
		end
		res.ir = held_ir;
		res.red = held_red;
		res.total = artifact_count;
		return res;
	endfunction

	function automatic int fit_sample(int v);
		return (v < 0) ? 0 : (v > SAMPLE_TOP) ? SAMPLE_TOP : v;
	endfunction

	function automatic script_step_t pair_row(int ir, int red);
		script_step_t s = '0;
		s.ir = SAMPLE_BITS'(ir);
		s.red = SAMPLE_BITS'(red);
		return s;
	endfunction

	function automatic script_step_t checked_row(int ir, int red, int w_ir, int w_red,
			bit w_flag, int w_total);
		script_step_t s = pair_row(ir, red);
		s.typed = 1'b1;
		s.want.ir = SAMPLE_BITS'(w_ir);
		s.want.red = SAMPLE_BITS'(w_red);
		s.want.is_artifact = w_flag;
		s.want.total = COUNT_BITS'(w_total);
		return s;
	endfunction

	function automatic script_step_t reg_row(logic [CFG_INDEX_BITS-1:0] idx, int data);
		script_step_t s = '0;
		s.is_write = 1'b1;
		s.index = idx;
		s.data = CFG_DATA_BITS'(data);
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	// one sample pair transfer; the expectation is queued at the accepting edge
	task automatic push_pair(logic [SAMPLE_BITS-1:0] ir, logic [SAMPLE_BITS-1:0] red,
			bit typed, clean_pair_t want);
		clean_pair_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pair_in.valid <= 1'b0;
			@(negedge clk);
		end
		pair_in.valid <= 1'b1;
		pair_in.ir_sample <= ir;
		pair_in.red_sample <= red;
		do
			@(posedge clk);
		while (!pair_in.ready);
		predicted = filter_pair(ir, red);
		clean_due.push_back(typed ? want : predicted);
		pairs_sent++;
	endtask

	// stop sending and wait until every queued result has come out
	task automatic drain_results();
		@(negedge clk);
		pair_in.valid <= 1'b0;
		while (clean_due.size() != 0)
			@(posedge clk);
	endtask

	// register write transfer, mirrored into the predictor
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int value);
		logic [CFG_DATA_BITS-1:0] data;
		data = CFG_DATA_BITS'(value);
		@(negedge clk);
		reg_wr.valid <= 1'b1;
		reg_wr.index <= idx;
		reg_wr.data <= data;
		do
			@(posedge clk);
		while (!reg_wr.ready);
		case (idx)
			REG_MIN_NORM:     min_norm_reg = data[MIN_NORM_BITS-1:0];
			REG_DERIV_FACTOR: factor_reg = data[FACTOR_BITS-1:0];
			REG_EMA_ALPHA:    alpha_reg = data[ALPHA_BITS-1:0];
			default:          ;
		endcase
		reg_writes++;
		@(negedge clk);
		reg_wr.valid <= 1'b0;
	endtask

	// result side back-pressure
	always @(negedge clk)
		pair_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		clean_pair_t want;
		if (arst_n && pair_out.valid && pair_out.ready) begin
			if (clean_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing due: ir %0d red %0d flag %0d",
					pair_out.ir_clean, pair_out.red_clean, pair_out.is_artifact));
			end else begin
				want = clean_due.pop_front();
				if (pair_out.ir_clean !== want.ir)
					report_mismatch($sformatf("result %0d ir_clean %0d, expected %0d",
						results_seen, pair_out.ir_clean, want.ir));
				if (pair_out.red_clean !== want.red)
					report_mismatch($sformatf("result %0d red_clean %0d, expected %0d",
						results_seen, pair_out.red_clean, want.red));
				if (pair_out.is_artifact !== want.is_artifact)
					report_mismatch($sformatf("result %0d is_artifact %0d, expected %0d",
						results_seen, pair_out.is_artifact, want.is_artifact));
				if (pair_out.artifact_total !== want.total)
					report_mismatch($sformatf("result %0d artifact_total %0d, expected %0d",
						results_seen, pair_out.artifact_total, want.total));
				if (want.is_artifact)
					artifacts_seen++;
			end
			results_seen++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				clean_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		script_step_t step;
		int trace_ir;
		int trace_red;
		int pick;
		int span;
		logic [SAMPLE_BITS-1:0] ir;
		logic [SAMPLE_BITS-1:0] red;

		// known levels on every input from time zero
		arst_n = 1'b0;
		pair_in.valid = 1'b0;
		pair_in.ir_sample = '0;
		pair_in.red_sample = '0;
		pair_out.ready = 1'b0;
		reg_wr.valid = 1'b0;
		reg_wr.index = '0;
		reg_wr.data = '0;

		// predictor reset state
		pair_held = 1'b0;
		held_ir = '0;
		held_red = '0;
		deriv_avg = '0;
		artifact_count = '0;
		min_norm_reg = MIN_NORM_BITS'(5243);
		factor_reg = FACTOR_BITS'(10);
		alpha_reg = ALPHA_BITS'(3277);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed script: first pair, extremes, zero factor, seeding, alpha limits
		script.push_back(checked_row(0, 0, 0, 0, 1'b0, 0));
		script.push_back(checked_row(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, 1'b0, 0));
		script.push_back(pair_row(0, 0));
		script.push_back(reg_row(REG_DERIV_FACTOR, 0));
		script.push_back(checked_row(0, 5, 0, 5, 1'b0, 0));
		script.push_back(checked_row(SAMPLE_TOP, 7, 0, 5, 1'b1, 1));
		script.push_back(reg_row(REG_MIN_NORM, 24'hFFFFFF));
		script.push_back(checked_row(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, 1'b0, 1));
		script.push_back(reg_row(REG_MIN_NORM, 0));
		script.push_back(checked_row(SAMPLE_TOP - 1, 1, SAMPLE_TOP - 1, 1, 1'b0, 1));
		script.push_back(checked_row(0, 3, SAMPLE_TOP - 1, 1, 1'b1, 2));
		script.push_back(reg_row(REG_EMA_ALPHA, 24'h01FFFF));
		script.push_back(reg_row(REG_DERIV_FACTOR, 255));
		script.push_back(reg_row(REG_MIN_NORM, 5243));
		script.push_back(pair_row(SAMPLE_TOP - 1, 9));
		script.push_back(pair_row(131071, SAMPLE_TOP));
		script.push_back(reg_row(REG_EMA_ALPHA, 0));
		script.push_back(pair_row(1, 131072));
		script.push_back(pair_row(SAMPLE_TOP, 0));
		script.push_back(reg_row(REG_UNUSED, 0));
		script.push_back(reg_row(REG_EMA_ALPHA, 65536));
		script.push_back(pair_row(65536, 196608));
		script.push_back(pair_row(2, 65535));

		foreach (script[k]) begin
			step = script[k];
			if (step.is_write) begin
				drain_results();
				write_reg(step.index, int'(step.data));
			end else begin
				push_pair(step.ir, step.red, step.typed, step.want);
			end
		end

		// random phases: pulse-like traces with spikes, under each idling mode
		trace_ir = 120000;
		trace_red = 90000;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			case (p)
				0: begin
					write_reg(REG_MIN_NORM, 5243);
					write_reg(REG_DERIV_FACTOR, 10);
					write_reg(REG_EMA_ALPHA, 3277);
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					write_reg(REG_MIN_NORM, 0);
					write_reg(REG_DERIV_FACTOR, 1);
					write_reg(REG_EMA_ALPHA, 65536);
					send_idle_pct = 82;
					recv_stall_pct = 0;
				end
				2: begin
					write_reg(REG_MIN_NORM, int'($urandom_range(0, 20000)));
					write_reg(REG_DERIV_FACTOR, 255);
					write_reg(REG_EMA_ALPHA, 0);
					send_idle_pct = 0;
					recv_stall_pct = 82;
				end
				default: begin
					write_reg(REG_UNUSED, int'($urandom));
					write_reg(REG_MIN_NORM, int'($urandom_range(0, 40000)));
					write_reg(REG_DERIV_FACTOR, int'($urandom));
					write_reg(REG_EMA_ALPHA, int'($urandom));
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase

			for (int n = 0; n < PHASE_PAIRS; n++) begin
				// in the first phase, hold off now and then until the pipeline is empty
				if (p == 0 && n % 90 == 45)
					drain_results();
				pick = $urandom_range(0, 99);
				if (pick < 72) begin
					// smooth pulse: small step around the trace
					span = trace_ir / 64 + 4;
					trace_ir = fit_sample(trace_ir + int'($urandom_range(0, span)) - span / 2);
					trace_red = fit_sample(trace_red + int'($urandom_range(0, span)) - span / 2);
					ir = SAMPLE_BITS'(trace_ir);
					red = SAMPLE_BITS'(trace_red);
				end else if (pick < 84) begin
					// motion spike, trace kept so the next pairs return to it
					ir = SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP));
					red = SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP));
				end else if (pick < 96) begin
					// new baseline anywhere in range
					trace_ir = $urandom_range(0, SAMPLE_TOP);
					trace_red = $urandom_range(0, SAMPLE_TOP);
					ir = SAMPLE_BITS'(trace_ir);
					red = SAMPLE_BITS'(trace_red);
				end else begin
					// flat repeat or dark sample
					ir = pick[0] ? SAMPLE_BITS'(trace_ir) : '0;
					red = pick[0] ? SAMPLE_BITS'(trace_red) : '0;
				end
				push_pair(ir, red, 1'b0, '0);
			end
		end

		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		if (clean_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", clean_due.size()));

		$display("covered %0d sample pairs, %0d results (%0d artifacts), %0d register writes",
			pairs_sent, results_seen, artifacts_seen, reg_writes);
		$display("four idling modes, threshold extremes, zero factor and saturated derivatives");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule : testbench
